// ----- design/ftps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftps_pkg
// Shared types and constants for the follow-target position step block.
// ----------------------------------------------------------------------------
package ftps_pkg;

  localparam int CoordW = 32;
  localparam int AmtW   = 31;
  localparam int ThrW   = 32;

  localparam logic [ThrW-1:0] ThrReset = 32'd66;

  // follow modes
  localparam logic OpInterp = 1'b0;
  localparam logic OpMove   = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [CoordW-1:0] self_x;
    logic signed [CoordW-1:0] self_y;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic [AmtW-1:0]          amount;
  } ftps_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] new_x;
    logic signed [CoordW-1:0] new_y;
    logic                     arrived;
  } ftps_out_t;

endpackage
`default_nettype wire

// ----- design/ftps_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftps_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ftps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/follow_target_position_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// follow_target_position_step
// Moves a follower toward its target by interpolation or bounded movement.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken per clock while the output buffer has
// room, and its result is offered through 71 registers (4 front stages for
// delta, squares, products and the arrival decision, 33 stages of the
// bit-per-stage square root, 1 handoff stage, 32 stages of the bit-per-stage
// divider for both axes in parallel, 1 output buffer entry). A two-entry
// output buffer holds finished results; input ready drops only while that
// buffer is full, and the whole pipeline then holds.
// ----------------------------------------------------------------------------
module follow_target_position_step #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ftps_pkg::ThrW-1:0] cfg_wdata_i,
  ftps_stream_if.sink                    in_i,
  ftps_stream_if.source                  out_o
);
  import ftps_pkg::*;

  localparam int SqN = 33;
  localparam int DvN = 32;

  typedef struct packed {
    logic              opcode;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       tx;
    logic [31:0]       ty;
    logic [AmtW-1:0]   amt;
    logic              negx;
    logic              negy;
    logic [31:0]       ax;
    logic [31:0]       ay;
  } sa_t;

  typedef struct packed {
    logic              opcode;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       tx;
    logic [31:0]       ty;
    logic              negx;
    logic              negy;
    logic [63:0]       sqx;
    logic [63:0]       sqy;
    logic [61:0]       amt2;
    logic [62:0]       px;
    logic [62:0]       py;
  } sb_t;

  typedef struct packed {
    logic              opcode;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       tx;
    logic [31:0]       ty;
    logic              negx;
    logic              negy;
    logic [64:0]       s;
    logic              arr;
    logic              land;
    logic [62:0]       px;
    logic [62:0]       py;
  } sc_t;

  typedef struct packed {
    logic [64:0]       s;
    logic [32:0]       q;
    logic [34:0]       r;
    logic [62:0]       px;
    logic [62:0]       py;
    logic              negx;
    logic              negy;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       ex;
    logic [31:0]       ey;
    logic              earr;
    logic              ndiv;
  } sq_t;

  typedef struct packed {
    logic [32:0]       divisor;
    logic [32:0]       rx;
    logic [32:0]       ry;
    logic [31:0]       qx;
    logic [31:0]       qy;
    logic [62:0]       px;
    logic [62:0]       py;
    logic              negx;
    logic              negy;
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       ex;
    logic [31:0]       ey;
    logic              earr;
    logic              ndiv;
  } dv_t;

  // saturate a signed 65-bit sum to the coordinate range
  function automatic logic [31:0] sat_coord(input logic [64:0] v);
    logic [31:0] res;
    if (!v[64] && (|v[63:31])) begin
      res = 32'h7FFF_FFFF;
    end else if (v[64] && !(&v[63:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // position plus signed step, saturated
  function automatic logic [31:0] add_step(input logic [31:0] s, input logic neg,
                                           input logic [62:0] mag);
    logic [64:0] s65;
    logic [64:0] m65;
    s65 = {{33{s[31]}}, s};
    m65 = {2'b00, mag};
    return sat_coord(neg ? s65 - m65 : s65 + m65);
  endfunction

  logic             en;
  logic [ThrW-1:0]  thr_q;
  logic             va_q, vb_q, vc_q;
  sa_t              a_d, a_q;
  sb_t              b_d, b_q;
  sc_t              c_d, c_q;
  sq_t              sq_q  [0:SqN];
  logic             sqv_q [0:SqN];
  sq_t              sq0_d;
  dv_t              dv_q  [0:DvN];
  logic             dvv_q [0:DvN];
  dv_t              dv0_d;
  ftps_out_t        res_d;
  ftps_out_t        ob0_q, ob1_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  logic [32:0]      dxa, dya, ndx, ndy;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // advance the pipeline while the output buffer has room
  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // stage A: deltas and magnitudes
  always_comb begin
    dxa = {in_i.payload.target_x[31], in_i.payload.target_x}
        - {in_i.payload.self_x[31], in_i.payload.self_x};
    dya = {in_i.payload.target_y[31], in_i.payload.target_y}
        - {in_i.payload.self_y[31], in_i.payload.self_y};
    ndx = -dxa;
    ndy = -dya;
    a_d.opcode = in_i.payload.opcode;
    a_d.sx     = in_i.payload.self_x;
    a_d.sy     = in_i.payload.self_y;
    a_d.tx     = in_i.payload.target_x;
    a_d.ty     = in_i.payload.target_y;
    a_d.amt    = in_i.payload.amount;
    a_d.negx   = dxa[32];
    a_d.negy   = dya[32];
    a_d.ax     = dxa[32] ? ndx[31:0] : dxa[31:0];
    a_d.ay     = dya[32] ? ndy[31:0] : dya[31:0];
  end

  // stage B: squares and products
  always_comb begin
    b_d.opcode = a_q.opcode;
    b_d.sx     = a_q.sx;
    b_d.sy     = a_q.sy;
    b_d.tx     = a_q.tx;
    b_d.ty     = a_q.ty;
    b_d.negx   = a_q.negx;
    b_d.negy   = a_q.negy;
    b_d.sqx    = {32'd0, a_q.ax} * {32'd0, a_q.ax};
    b_d.sqy    = {32'd0, a_q.ay} * {32'd0, a_q.ay};
    b_d.amt2   = {31'd0, a_q.amt} * {31'd0, a_q.amt};
    b_d.px     = {31'd0, a_q.ax} * {32'd0, a_q.amt};
    b_d.py     = {31'd0, a_q.ay} * {32'd0, a_q.amt};
  end

  // stage C: squared distance, arrival and landing tests
  always_comb begin
    c_d.opcode = b_q.opcode;
    c_d.sx     = b_q.sx;
    c_d.sy     = b_q.sy;
    c_d.tx     = b_q.tx;
    c_d.ty     = b_q.ty;
    c_d.negx   = b_q.negx;
    c_d.negy   = b_q.negy;
    c_d.s      = {1'b0, b_q.sqx} + {1'b0, b_q.sqy};
    c_d.arr    = (c_d.s >> FRAC_BITS) <= {33'd0, thr_q};
    c_d.land   = c_d.s <= {3'd0, b_q.amt2};
    c_d.px     = b_q.px;
    c_d.py     = b_q.py;
  end

  // stage D: early result for every case but bounded movement that does not land
  always_comb begin
    sq0_d.s    = c_q.s;
    sq0_d.q    = '0;
    sq0_d.r    = '0;
    sq0_d.px   = c_q.px;
    sq0_d.py   = c_q.py;
    sq0_d.negx = c_q.negx;
    sq0_d.negy = c_q.negy;
    sq0_d.sx   = c_q.sx;
    sq0_d.sy   = c_q.sy;
    sq0_d.earr = 1'b0;
    sq0_d.ndiv = 1'b0;
    if (c_q.arr) begin
      sq0_d.ex   = c_q.sx;
      sq0_d.ey   = c_q.sy;
      sq0_d.earr = 1'b1;
    end else if (c_q.opcode == OpInterp) begin
      sq0_d.ex = add_step(c_q.sx, c_q.negx, c_q.px >> FRAC_BITS);
      sq0_d.ey = add_step(c_q.sy, c_q.negy, c_q.py >> FRAC_BITS);
    end else if (c_q.land) begin
      sq0_d.ex = c_q.tx;
      sq0_d.ey = c_q.ty;
    end else begin
      sq0_d.ex   = c_q.sx;
      sq0_d.ey   = c_q.sy;
      sq0_d.ndiv = 1'b1;
    end
  end

  // front stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
      sqv_q[0] <= 1'b0;
    end else if (en) begin
      va_q     <= in_i.valid;
      vb_q     <= va_q;
      vc_q     <= vb_q;
      sqv_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      sq_q[0]  <= sq0_d;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    sq_t         sq_d;
    logic [65:0] sp;
    logic [36:0] rs;
    logic [36:0] t;

    always_comb begin
      sq_d = sq_q[k];
      sp   = {1'b0, sq_q[k].s};
      rs   = {sq_q[k].r, sp[65-2*k -: 2]};
      t    = {2'b00, sq_q[k].q, 2'b01};
      if (rs >= t) begin
        sq_d.r = 35'(rs - t);
        sq_d.q = {sq_q[k].q[31:0], 1'b1};
      end else begin
        sq_d.r = rs[34:0];
        sq_d.q = {sq_q[k].q[31:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k+1] <= 1'b0;
      end else if (en) begin
        sqv_q[k+1] <= sqv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= sq_d;
      end
    end
  end

  // hand the root to the dividers
  always_comb begin
    dv0_d.divisor = sq_q[SqN].q;
    dv0_d.rx   = {2'b00, sq_q[SqN].px[62:32]};
    dv0_d.ry   = {2'b00, sq_q[SqN].py[62:32]};
    dv0_d.qx   = '0;
    dv0_d.qy   = '0;
    dv0_d.px   = sq_q[SqN].px;
    dv0_d.py   = sq_q[SqN].py;
    dv0_d.negx = sq_q[SqN].negx;
    dv0_d.negy = sq_q[SqN].negy;
    dv0_d.sx   = sq_q[SqN].sx;
    dv0_d.sy   = sq_q[SqN].sy;
    dv0_d.ex   = sq_q[SqN].ex;
    dv0_d.ey   = sq_q[SqN].ey;
    dv0_d.earr = sq_q[SqN].earr;
    dv0_d.ndiv = sq_q[SqN].ndiv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= sqv_q[SqN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= dv0_d;
    end
  end

  // restoring divide, one quotient bit per stage on each axis
  for (genvar k = 0; k < DvN; k++) begin : g_div
    dv_t         dv_d;
    logic [33:0] rsx;
    logic [33:0] rsy;
    logic [33:0] dd;

    always_comb begin
      dv_d = dv_q[k];
      dd   = {1'b0, dv_q[k].divisor};
      rsx  = {dv_q[k].rx, dv_q[k].px[31-k]};
      rsy  = {dv_q[k].ry, dv_q[k].py[31-k]};
      if (rsx >= dd) begin
        dv_d.rx = 33'(rsx - dd);
        dv_d.qx = {dv_q[k].qx[30:0], 1'b1};
      end else begin
        dv_d.rx = rsx[32:0];
        dv_d.qx = {dv_q[k].qx[30:0], 1'b0};
      end
      if (rsy >= dd) begin
        dv_d.ry = 33'(rsy - dd);
        dv_d.qy = {dv_q[k].qy[30:0], 1'b1};
      end else begin
        dv_d.ry = rsy[32:0];
        dv_d.qy = {dv_q[k].qy[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (en) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= dv_d;
      end
    end
  end

  // pick the final position
  always_comb begin
    if (dv_q[DvN].ndiv) begin
      res_d.new_x   = add_step(dv_q[DvN].sx, dv_q[DvN].negx, {31'd0, dv_q[DvN].qx});
      res_d.new_y   = add_step(dv_q[DvN].sy, dv_q[DvN].negy, {31'd0, dv_q[DvN].qy});
      res_d.arrived = 1'b0;
    end else begin
      res_d.new_x   = dv_q[DvN].ex;
      res_d.new_y   = dv_q[DvN].ey;
      res_d.arrived = dv_q[DvN].earr;
    end
  end

  // two-entry output buffer
  assign push = dvv_q[DvN] && en;
  assign pop  = (cnt_q != 2'd0) && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q - {1'b0, pop}) == 2'd0)) begin
      ob0_q <= res_d;
    end else if (pop) begin
      ob0_q <= ob1_q;
    end
    if (push && ((cnt_q - {1'b0, pop}) != 2'd0)) begin
      ob1_q <= res_d;
    end
  end

  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.payload = ob0_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("output buffer lost a transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> $stable(dvv_q[DvN])) else $error("pipeline moved while held");

endmodule
`default_nettype wire
